// ===== rtl/breakpoint_address_table_assert.svh =====
// Assertion macros shared by the breakpoint address table RTL.
`ifndef BREAKPOINT_ADDRESS_TABLE_ASSERT_SVH
`define BREAKPOINT_ADDRESS_TABLE_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define BAT_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A condition that holds in the same cycle as its trigger.
`define BAT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that holds in the cycle after its trigger.
`define BAT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bat_pkg.sv =====
// Package with the types and constants of the breakpoint address table.
`default_nettype none

package bat_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W      = 32;
  localparam int USED_W      = 5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t               operation;
    logic [ADDR_W-1:0] address;
  } bat_in_t;

  typedef struct packed {
    logic              accepted;
    logic              hit;
    logic [USED_W-1:0] entries_used;
  } bat_out_t;

  typedef struct packed {
    logic              compare;
    logic              remove;
    logic [ADDR_W-1:0] address;
  } bat_cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/bat_cell.sv =====
// One entry of the breakpoint table with its comparator and compaction link.
`default_nettype none

module bat_cell import bat_pkg::*; (
  input  wire logic          clk,
  input  wire bat_cell_ctl_t ctl,
  input  wire logic          write_en,
  input  wire logic          occupied,
  input  wire logic          occupied_next,
  input  wire logic [ADDR_W-1:0] next_entry,
  input  wire logic          seen_in,
  output logic               seen_out,
  output logic               hit,
  output logic [ADDR_W-1:0]  entry
);

  logic [ADDR_W-1:0] entry_r;
  logic [ADDR_W-1:0] entry_nxt;
  logic              match_r;
  logic              shift;

  assign hit      = match_r & occupied;
  assign seen_out = seen_in | hit;
  assign shift    = ctl.remove & seen_out & occupied_next;
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (write_en) begin
      entry_nxt = ctl.address;
    end else if (shift) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.compare) begin
      match_r <= (entry_r == ctl.address);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/breakpoint_address_table.sv =====
// Top level of the breakpoint address table: control, entry count and the row of cells.
//
// Each input word carries an operation (add, delete, check, clear) and a
// 32-bit address. Every accepted word yields exactly one result word with
// accepted, hit and the number of entries in use after the operation.
// An item passes a compare step and then an update step: in the first every
// cell compares its entry with the address in parallel, in the second the
// match chain through the row of cells settles and the table is updated. The
// result is registered and is valid on the cycle after the update. No new
// word is taken during the compare-then-update pass over the cells. A delete
// closes the gap by shifting every later entry down one cell. The next word
// is taken while a result is being taken, but not while it is held: when the
// receiver stalls, in_ready stays low until out_ready returns. Reset empties
// the table; entries are not cleared and no clearing pass is needed.
`default_nettype none

module breakpoint_address_table import bat_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire bat_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output bat_out_t      out_data
);

`include "breakpoint_address_table_assert.svh"

  logic              busy_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  bat_out_t          out_data_r;
  bat_out_t          out_data_nxt;
  op_t               op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  logic                        in_fire;
  logic                        found;
  logic                        full;
  logic                        do_write;
  bat_cell_ctl_t               ctl;
  logic [MAX_ENTRIES:0]        occ;
  logic [MAX_ENTRIES-1:0]      wsel;
  logic [MAX_ENTRIES:0]        seen;
  logic [MAX_ENTRIES-1:0]      hits;
  logic [ADDR_W-1:0]           entries [MAX_ENTRIES];

  assign in_ready  = !busy_r && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign found = seen[MAX_ENTRIES];
  assign full  = (count_r == CNT_W'(MAX_ENTRIES));

  assign ctl.compare = in_fire;
  assign ctl.remove  = busy_r && (op_r == OP_DELETE) && found;
  assign ctl.address = busy_r ? addr_r : in_data.address;

  assign seen[0]          = 1'b0;
  assign occ[MAX_ENTRIES] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [ADDR_W-1:0] nb_entry;

    assign occ[i]  = (CNT_W'(i) < count_r);
    assign wsel[i] = do_write && (count_r == CNT_W'(i));

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign nb_entry = entries[i];
    end else begin : g_mid
      assign nb_entry = entries[i+1];
    end

    bat_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .write_en     (wsel[i]),
      .occupied     (occ[i]),
      .occupied_next(occ[i+1]),
      .next_entry   (nb_entry),
      .seen_in      (seen[i]),
      .seen_out     (seen[i+1]),
      .hit          (hits[i]),
      .entry        (entries[i])
    );
  end

  always_comb begin
    do_write     = 1'b0;
    count_nxt    = count_r;
    out_data_nxt = out_data_r;
    if (busy_r) begin
      out_data_nxt.accepted = 1'b1;
      out_data_nxt.hit      = 1'b0;
      case (op_r)
        OP_ADD: begin
          if (!found) begin
            if (full) begin
              out_data_nxt.accepted = 1'b0;
            end else begin
              do_write  = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end
        OP_DELETE: begin
          if (found) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        OP_CHECK: begin
          out_data_nxt.hit = found;
        end
        OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
      out_data_nxt.entries_used = USED_W'(count_nxt);
    end
  end

  assign out_valid_nxt = busy_r || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= in_fire;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      op_r   <= in_data.operation;
      addr_r <= in_data.address;
    end
  end

  `BAT_CHECK(a_count_range, count_r <= CNT_W'(MAX_ENTRIES), "entry count above table size")
  `BAT_IMPLY(a_unique, busy_r, $onehot0(hits), "address stored in more than one entry")
  `BAT_IMPLY(a_reject_full, out_valid_r && !out_data_r.accepted, full,
             "add rejected while table not full")
  `BAT_NEXT(a_one_item, busy_r, !busy_r && out_valid_r, "update did not produce a result word")

endmodule

`default_nettype wire
